/* hdl/double_ended_queue_assert.svh */
// ----------------------------------------------------------------------------
// double_ended_queue assertion macros
// concurrent checks that are compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// checked only outside of reset
`define DEQ_ASSERT(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define DEQ_ASSERT_ALWAYS(name, clock, prop, msg) \
  name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define DEQ_ASSERT(name, clock, reset, prop, msg)
`define DEQ_ASSERT_ALWAYS(name, clock, prop, msg)

`endif

`endif

/* hdl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and widths of the double-ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

  localparam int ACT_W  = 3;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 11;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_SIZE       = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_t;

  // everything about a result except the word read from the store
  typedef struct packed {
    logic              status;
    logic              use_ram;
    logic [DATA_W-1:0] data;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

/* hdl/deq_ram.sv */
// ----------------------------------------------------------------------------
// deq_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hdl/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// head and count registers, store address and result selection per action
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module deq_ctrl #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  deq_pkg::action_t              action,
  input  logic signed [deq_pkg::DATA_W-1:0] value,
  output logic                          ram_we,
  output logic                          ram_re,
  output logic [$clog2(DEPTH)-1:0]      ram_addr,
  output logic [deq_pkg::DATA_W-1:0]    ram_wdata,
  output deq_pkg::result_t              meta
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_wrap;
  logic [SW-1:0] last_sum;
  logic [SW-1:0] last_wrap;
  logic [SW-1:0] head_plus;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] last_pos;
  logic [DATA_W-1:0] occ_ext;
  logic          empty;
  logic          full;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  // positions modulo depth; every sum stays below twice the depth (last_sum only when not empty)
  assign tail_sum  = SW'(head) + SW'(count);
  assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
  assign tail_pos  = tail_wrap[AW-1:0];
  assign last_sum  = tail_sum - SW'(1);
  assign last_wrap = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;
  assign last_pos  = last_wrap[AW-1:0];
  assign head_plus = SW'(head) + SW'(1);
  assign head_inc  = (head_plus == SW'(DEPTH)) ? '0 : head_plus[AW-1:0];
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  assign ram_wdata = value;
  assign occ_ext   = DATA_W'(count_next);

  always_comb begin
    head_next      = head;
    count_next     = count;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = head;
    meta.status    = 1'b0;
    meta.use_ram   = 1'b0;
    meta.data      = '0;
    unique case (action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          meta.status = 1'b1;
        end else begin
          head_next  = head_dec;
          count_next = count + CW'(1);
          ram_addr   = head_dec;
          ram_we     = accept;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          meta.status = 1'b1;
        end else begin
          count_next = count + CW'(1);
          ram_addr   = tail_pos;
          ram_we     = accept;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          meta.status = 1'b1;
        end else begin
          head_next    = head_inc;
          count_next   = count - CW'(1);
          ram_re       = accept;
          meta.use_ram = 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          meta.status = 1'b1;
        end else begin
          count_next   = count - CW'(1);
          ram_addr     = last_pos;
          ram_re       = accept;
          meta.use_ram = 1'b1;
        end
      end
      ACT_PEEK_FRONT: begin
        if (empty) begin
          meta.status = 1'b1;
        end else begin
          ram_re       = accept;
          meta.use_ram = 1'b1;
        end
      end
      ACT_PEEK_BACK: begin
        if (empty) begin
          meta.status = 1'b1;
        end else begin
          ram_addr     = last_pos;
          ram_re       = accept;
          meta.use_ram = 1'b1;
        end
      end
      ACT_SIZE: begin
        meta.data = DATA_W'(count);
      end
      ACT_CLEAR: begin
        head_next  = tail_pos;
        count_next = '0;
      end
    endcase
    meta.occupancy = occ_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  `DEQ_ASSERT(a_count_range, clk, rst, count <= CW'(DEPTH), "element count above depth")
  `DEQ_ASSERT(a_head_range, clk, rst, head < AW'(DEPTH - 1) || head == AW'(DEPTH - 1), "head outside store")
  `DEQ_ASSERT(a_full_push_holds, clk, rst, accept && full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK) |=> $stable(count) && $stable(head), "push on full queue changed state")
  `DEQ_ASSERT(a_one_port_use, clk, rst, !(ram_we && ram_re), "store read and written together")

endmodule

/* hdl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// deque of signed 32-bit words in a circular store, one result per word
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (low bit first)
//  s_axis    in         action[2:0], value[34:3], zero pad to 40 bits
//  m_axis    out        status[0], data[32:1], occupancy[43:33], zero pad to 48
//
//  one word accepted per cycle while no result waits unaccepted; its result is
//  offered on the next cycle, set by the registered read port of the store
//  reset clears head, count and m_tvalid only; the store needs no clearing pass
//  while a result waits with m_tready low, s_tready is low and all state holds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action, value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status, data, occupancy
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              in_fire;
  logic              out_fire;
  action_t           action;
  logic signed [DATA_W-1:0] value;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  result_t           meta;
  result_t           meta_q;
  logic [DATA_W-1:0] data_out;

  assign action   = action_t'(s_tdata[ACT_W-1:0]);
  assign value    = signed'(s_tdata[ACT_W+DATA_W-1:ACT_W]);
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_fire),
    .action    (action),
    .value     (value),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .meta      (meta)
  );

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      meta_q <= meta;
    end
  end

  // ram read data stays put until the next accepted word
  assign data_out = meta_q.use_ram ? ram_rdata : meta_q.data;
  assign m_tdata  = {4'b0, meta_q.occupancy, data_out, meta_q.status};

  `DEQ_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !m_tvalid, "result offered after reset")
  `DEQ_ASSERT(a_accept_gives_result, clk, rst, in_fire |=> m_tvalid, "accepted word gave no result")
  `DEQ_ASSERT(a_drain, clk, rst, out_fire && !in_fire |=> !m_tvalid, "result repeated")
  `DEQ_ASSERT(a_read_only_with_ram, clk, rst, in_fire && ram_re |-> meta.use_ram && !meta.status, "store read for a result that ignores it")

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for double_ended_queue: a table of directed actions,
// a deep fill with a receiver hold-off, a drain past empty, then random mixes
// with shifting push bias; results are checked against typed rows or a shadow deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int DEQ_DEPTH    = 1024;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int FILL_WORDS   = 200;
  localparam int RAND_EPOCHS  = 3;
  localparam int EPOCH_WORDS  = 60;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] data;
    logic [OCC_W-1:0]  occupancy;
  } deq_result_t;

  typedef struct packed {
    action_t           act;
    logic [DATA_W-1:0] val;
    logic              fixed;   // result typed in below, not predicted
    deq_result_t       want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // action, value
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // status, data, occupancy

  // travel with s_tdata so the monitor sees them on the accepting edge
  logic        row_fixed;
  deq_result_t row_want;

  logic        steady       = 1'b0;
  logic        hold_request = 1'b0;

  // shadow deque
  logic [DATA_W-1:0] shadow_store [DEQ_DEPTH];
  logic [9:0]        shadow_head  = '0;
  logic [OCC_W-1:0]  shadow_count = '0;

  deq_result_t deq_results_due [$];
  int          fail_count     = 0;
  int          words_sent     = 0;
  int          results_seen   = 0;
  int          error_results  = 0;
  int          peak_count     = 0;

  dir_row_t dir_rows [22];

  double_ended_queue #(.DEPTH(DEQ_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deq_result_t apply_action(action_t act, logic [DATA_W-1:0] val);
    deq_result_t res;
    logic [9:0]  tail;
    res  = '0;
    tail = shadow_head + shadow_count[9:0] - 10'd1;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_count == OCC_W'(DEQ_DEPTH)) begin
          res.status = 1'b1;
        end else if (act == ACT_PUSH_FRONT) begin
          shadow_head = shadow_head - 10'd1;
          shadow_store[shadow_head] = val;
          shadow_count = shadow_count + 11'd1;
        end else begin
          shadow_store[shadow_head + shadow_count[9:0]] = val;
          shadow_count = shadow_count + 11'd1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (shadow_count == '0) begin
          res.status = 1'b1;
        end else begin
          res.data = (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT) ?
                     shadow_store[shadow_head] : shadow_store[tail];
          if (act == ACT_POP_FRONT) begin
            shadow_head = shadow_head + 10'd1;
          end
          if (act == ACT_POP_FRONT || act == ACT_POP_BACK) begin
            shadow_count = shadow_count - 11'd1;
          end
        end
      end
      ACT_SIZE: begin
        res.data = DATA_W'(shadow_count);
      end
      default: begin
        // clear moves the head past the discarded words
        shadow_head  = shadow_head + shadow_count[9:0];
        shadow_count = '0;
      end
    endcase
    res.occupancy = shadow_count;
    return res;
  endfunction

  task automatic note_failure(input string what, input deq_result_t want,
                              input deq_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%t %s: want st=%0b data=%h occ=%0d, got st=%0b data=%h occ=%0d",
               $realtime, what, want.status, want.data, want.occupancy,
               got.status, got.data, got.occupancy);
    end
  endtask

  // result check first: a result never belongs to the word accepted on the same edge
  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[32:1], m_tdata[43:33]};
        results_seen++;
        if (deq_results_due.size() == 0) begin
          note_failure("result with nothing outstanding", '0, got);
        end else begin
          want = deq_results_due[0];
          deq_results_due.delete(0);
          if (got !== want) begin
            note_failure("result mismatch", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_action(action_t'(s_tdata[2:0]), s_tdata[34:3]);
        if (row_fixed) begin
          want = row_want;
        end
        deq_results_due.insert(deq_results_due.size(), want);
        words_sent++;
        if (want.status) begin
          error_results++;
        end
        if (int'(shadow_count) > peak_count) begin
          peak_count = int'(shadow_count);
        end
      end
    end
  end

  // receiver
  initial begin
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input action_t act, input logic [DATA_W-1:0] val,
                           input logic fixed = 1'b0, input deq_result_t want = '0);
    if (!steady && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {5'd0, val, act};
    row_fixed <= fixed;
    row_want  <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // sender pauses until every outstanding result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (deq_results_due.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic action_t pick_action(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 2) begin
      return ACT_CLEAR;
    end else if (r < 2 + push_pct) begin
      return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    end
    case ($urandom_range(9))
      0, 1, 2, 9: return ACT_POP_FRONT;
      3, 4, 5:    return ACT_POP_BACK;
      6:          return ACT_PEEK_FRONT;
      7:          return ACT_PEEK_BACK;
      default:    return ACT_SIZE;
    endcase
  endfunction

  initial begin
    int push_bias [RAND_EPOCHS];
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    row_fixed = 1'b0;
    row_want  = '0;
    push_bias = '{75, 25, 60};

    dir_rows = '{
      '{ACT_SIZE,       32'h0000_0000, 1'b1, '{1'b0, 32'd0,          11'd0}},
      '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '{1'b1, 32'd0,          11'd0}},
      '{ACT_POP_BACK,   32'hffff_ffff, 1'b1, '{1'b1, 32'd0,          11'd0}},
      '{ACT_PEEK_FRONT, 32'h0000_0000, 1'b1, '{1'b1, 32'd0,          11'd0}},
      '{ACT_PEEK_BACK,  32'h0000_0000, 1'b1, '{1'b1, 32'd0,          11'd0}},
      // head wraps below zero on the first front push
      '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, '{1'b0, 32'd0,          11'd1}},
      '{ACT_PUSH_BACK,  32'h7fff_ffff, 1'b1, '{1'b0, 32'd0,          11'd2}},
      '{ACT_PEEK_FRONT, 32'h0000_0000, 1'b1, '{1'b0, 32'h8000_0000,  11'd2}},
      '{ACT_PEEK_BACK,  32'h0000_0000, 1'b1, '{1'b0, 32'h7fff_ffff,  11'd2}},
      '{ACT_SIZE,       32'h0000_0000, 1'b1, '{1'b0, 32'd2,          11'd2}},
      '{ACT_PUSH_FRONT, 32'hffff_ffff, 1'b0, '0},
      '{ACT_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
      '{ACT_POP_BACK,   32'h5555_5555, 1'b0, '0},
      '{ACT_POP_FRONT,  32'haaaa_aaaa, 1'b0, '0},
      '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0},
      '{ACT_PUSH_BACK,  32'h5a5a_5a5a, 1'b0, '0},
      '{ACT_CLEAR,      32'hffff_ffff, 1'b1, '{1'b0, 32'd0,          11'd0}},
      '{ACT_PEEK_BACK,  32'h0000_0000, 1'b1, '{1'b1, 32'd0,          11'd0}},
      '{ACT_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
      '{ACT_POP_FRONT,  32'hdead_beef, 1'b0, '0},
      '{ACT_SIZE,       32'hffff_ffff, 1'b1, '{1'b0, 32'd0,          11'd0}},
      '{ACT_CLEAR,      32'h0000_0000, 1'b1, '{1'b0, 32'd0,          11'd0}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].act, dir_rows[i].val, dir_rows[i].fixed, dir_rows[i].want);
    end
    wait_for_results();

    // deep fill from both ends; long receiver hold-off early on
    for (int i = 0; i < FILL_WORDS; i++) begin
      if (i == 50) begin
        hold_request = 1'b1;
      end
      steady = (i >= 100 && i < 180);
      send_word($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_value());
    end
    steady = 1'b0;
    send_word(ACT_SIZE, $urandom);
    send_word(ACT_PEEK_FRONT, $urandom);
    send_word(ACT_PEEK_BACK, $urandom);

    // drain past empty
    for (int i = 0; i < FILL_WORDS + 3; i++) begin
      send_word($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
    end
    wait_for_results();

    for (int e = 0; e < RAND_EPOCHS; e++) begin
      for (int i = 0; i < EPOCH_WORDS; i++) begin
        send_word(pick_action(push_bias[e]), pick_value());
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (deq_results_due.size() != 0) begin
      note_failure("results never delivered", '0, '0);
    end

    $display("deque run: %0d words in, %0d results checked, %0d of them errors",
             words_sent, results_seen, error_results);
    $display("covered the empty limit, wraparound, clear, stalls, peak occupancy %0d",
             peak_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue.sv
tb/sv/tb.sv
